/* rtl/u8v_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants of the utf-8 stream validator
package u8v_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int OUT_OFFSET_BITS     = 32;

   // status codes
   localparam logic [1:0] STATUS_VALID     = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CONT  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // byte ranges
   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam logic [7:0] LEAD2_MIN = 8'hC0;
   localparam logic [7:0] LEAD2_MAX = 8'hDF;
   localparam logic [7:0] LEAD3_MIN = 8'hE0;
   localparam logic [7:0] LEAD3_MAX = 8'hEF;
   localparam logic [7:0] LEAD4_MIN = 8'hF0;
   localparam logic [7:0] LEAD4_MAX = 8'hF4;
   localparam logic [7:0] CONT_MIN  = 8'h80;
   localparam logic [7:0] CONT_MAX  = 8'hBF;

   typedef struct packed {
      logic       bad_lead;
      logic [1:0] owes;
      logic       is_cont;
   } byte_class_type;

endpackage

/* rtl/u8v_req_if.sv */
`timescale 1ns / 1ps
// input channel: one buffer word per handshake
interface u8v_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/u8v_rsp_if.sv */
`timescale 1ns / 1ps
// result channel: status and offset of one checked buffer
interface u8v_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] error_offset;

   modport source (output valid, output status, output error_offset, input ready);
   modport sink   (input valid, input status, input error_offset, output ready);
endinterface

/* rtl/u8v_classify.sv */
`timescale 1ns / 1ps
// classifies one word as lead byte or continuation byte, and flags bytes that cannot lead
module u8v_classify (
   input  logic [7:0]              data_byte,
   output u8v_pkg::byte_class_type byte_class
);

   always_comb begin
      byte_class          = '0;
      byte_class.is_cont  = (data_byte inside {[u8v_pkg::CONT_MIN:u8v_pkg::CONT_MAX]});
      if (data_byte <= u8v_pkg::ASCII_MAX) begin
         byte_class.owes = 2'd0;
      end else if (data_byte inside {[u8v_pkg::LEAD2_MIN:u8v_pkg::LEAD2_MAX]}) begin
         byte_class.owes = 2'd1;
      end else if (data_byte inside {[u8v_pkg::LEAD3_MIN:u8v_pkg::LEAD3_MAX]}) begin
         byte_class.owes = 2'd2;
      end else if (data_byte inside {[u8v_pkg::LEAD4_MIN:u8v_pkg::LEAD4_MAX]}) begin
         byte_class.owes = 2'd3;
      end else begin
         byte_class.bad_lead = 1'b1;
      end
   end

endmodule

/* rtl/u8v_scan.sv */
`timescale 1ns / 1ps
// sequence tracking state, first-error latch and result formation
module u8v_scan #(
   parameter int OFFSET_BITS = u8v_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output logic                   fire,
   output logic [1:0]             status,
   output logic [OFFSET_BITS-1:0] offset
);

   u8v_pkg::byte_class_type byte_class;

   logic [1:0]             owed_ff, owed_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   err_seen_ff, err_seen_in;
   logic [1:0]             err_kind_ff, err_kind_in;
   logic [OFFSET_BITS-1:0] err_pos_ff, err_pos_in;

   u8v_classify u_classify (
      .data_byte  (data_byte),
      .byte_class (byte_class)
   );

   always_comb begin
      owed_in     = owed_ff;
      err_seen_in = err_seen_ff;
      err_kind_in = err_kind_ff;
      err_pos_in  = err_pos_ff;
      pos_in      = (pos_ff == '1) ? pos_ff : pos_ff + OFFSET_BITS'(1);

      if (!err_seen_ff) begin
         if (owed_ff == 2'd0) begin
            if (byte_class.bad_lead) begin
               err_seen_in = 1'b1;
               err_kind_in = u8v_pkg::STATUS_BAD_LEAD;
               err_pos_in  = pos_ff;
            end else begin
               owed_in = byte_class.owes;
            end
         end else if (byte_class.is_cont) begin
            owed_in = owed_ff - 2'd1;
         end else begin
            err_seen_in = 1'b1;
            err_kind_in = u8v_pkg::STATUS_BAD_CONT;
            err_pos_in  = pos_ff;
         end
      end

      // result for a buffer ending on this word
      if (err_seen_in) begin
         status = err_kind_in;
         offset = err_pos_in;
      end else if (owed_in != 2'd0) begin
         status = u8v_pkg::STATUS_TRUNCATED;
         offset = pos_in;
      end else begin
         status = u8v_pkg::STATUS_VALID;
         offset = '0;
      end
   end

   assign fire = step && last_byte;

   always_ff @(posedge clock) begin
      if (reset || fire) begin
         owed_ff     <= 2'd0;
         pos_ff      <= '0;
         err_seen_ff <= 1'b0;
         err_kind_ff <= u8v_pkg::STATUS_VALID;
         err_pos_ff  <= '0;
      end else if (step) begin
         owed_ff     <= owed_in;
         pos_ff      <= pos_in;
         err_seen_ff <= err_seen_in;
         err_kind_ff <= err_kind_in;
         err_pos_ff  <= err_pos_in;
      end
   end

endmodule

/* rtl/utf8_stream_validator.sv */
`timescale 1ns / 1ps
// top level of the utf-8 stream validator
// checks a buffer, one byte per word, against permissive utf-8 framing
// (lead 00-7f alone, c0-df/e0-ef/f0-f4 owing one/two/three continuation bytes
// in 80-bf). one result word leaves per buffer, after its word marked last:
// status 0 valid, 1 bad lead byte, 2 bad continuation byte, 3 truncated, with
// the offset of the first offending byte, or the buffer length when truncated.
// overlong forms and surrogates are not flagged. throughput is one word per
// cycle while the result slot is free, set by the update of the sequence state;
// an accepted last word passes the input register and then the result register,
// and a stalled result can hold it in between. the byte position saturates at
// 2^OFFSET_BITS-1 and reported offsets clip at ffffffff.
module utf8_stream_validator #(
   parameter int OFFSET_BITS = u8v_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   u8v_req_if.sink   req_if,
   u8v_rsp_if.source rsp_if
);

   // width used to clip the internal offset onto the 32-bit port
   localparam int WIDE_BITS = (OFFSET_BITS > u8v_pkg::OUT_OFFSET_BITS) ?
                              OFFSET_BITS : u8v_pkg::OUT_OFFSET_BITS;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_offset_ff;

   logic                   out_free;
   logic                   step;
   logic                   fire;
   logic [1:0]             scan_status;
   logic [OFFSET_BITS-1:0] scan_offset;
   logic [WIDE_BITS-1:0]   offset_wide;
   logic [31:0]            offset_clip;

   // result slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // the registered word is consumed whenever a result could be stored
   assign step = in_valid_ff && out_free;

   // a new word enters when the input register is empty or draining
   assign req_if.ready = !in_valid_ff || step;

   assign in_valid_in = req_if.valid ? 1'b1 : (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.last_byte;
      end
   end

   u8v_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .fire      (fire),
      .status    (scan_status),
      .offset    (scan_offset)
   );

   // clip to the port width, saturating to all ones
   assign offset_wide = WIDE_BITS'(scan_offset);
   assign offset_clip = (offset_wide > WIDE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                        offset_wide[31:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= scan_status;
         rsp_offset_ff <= offset_clip;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.error_offset = rsp_offset_ff;

endmodule

/* rtl/u8v_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the utf-8 stream validator, bound to the top level
module u8v_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_error_offset
);

   // no result straight after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_error_offset))
      else $error("stalled result word changed");

   // a clean buffer reports offset zero
   a_valid_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == u8v_pkg::STATUS_VALID |-> rsp_error_offset == 32'd0)
      else $error("valid status with nonzero offset");

   // truncation reports the buffer length, never zero
   a_trunc_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == u8v_pkg::STATUS_TRUNCATED |-> rsp_error_offset != 32'd0)
      else $error("truncated status with zero length");

endmodule

bind utf8_stream_validator u8v_checker u_u8v_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_error_offset (rsp_if.error_offset)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the utf-8 stream validator: directed and random buffers
module testbench;
   import u8v_pkg::*;

   localparam int          CLOCK_PERIOD  = 8;
   localparam int          RESET_CYCLES  = 5;
   localparam int          RANDOM_WORDS  = 1950;
   // wait after the last verdict is back, to catch stray results
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          REPORT_LIMIT  = 10;
   localparam logic [31:0] POSITION_MAX  = '1;

   typedef logic [7:0] octet_queue_type[$];

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] offset;
   } verdict_type;

   logic clock;
   logic reset;

   u8v_req_if req ();
   u8v_rsp_if rsp ();

   utf8_stream_validator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   // predicted decoder state, kept in step with every accepted word
   logic [1:0]  owed_conts;
   logic [31:0] next_offset;
   logic        fault_latched;
   logic [1:0]  fault_kind;
   logic [31:0] fault_offset;

   // verdicts still owed by the block, oldest first
   verdict_type pending_verdicts[$];

   int words_sent    = 0;
   int buffers_sent  = 0;
   int verdicts_seen = 0;
   int mismatches    = 0;
   int burst_left    = 0;
   int cycle_count   = 0;
   int status_hits[4] = '{0, 0, 0, 0};

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // back to the state of a fresh buffer
   task automatic clear_decoder();
      owed_conts    = 2'd0;
      next_offset   = '0;
      fault_latched = 1'b0;
      fault_kind    = STATUS_VALID;
      fault_offset  = '0;
   endtask

   // advance the prediction by one accepted word; a word marked last
   // queues the verdict for its buffer
   task automatic decode_word(input logic [7:0] octet, input logic last);
      verdict_type verdict;
      if (!fault_latched) begin
         if (owed_conts == 2'd0) begin
            // expecting a lead byte
            if (octet <= ASCII_MAX)
               owed_conts = 2'd0;
            else if (octet >= LEAD2_MIN && octet <= LEAD2_MAX)
               owed_conts = 2'd1;
            else if (octet >= LEAD3_MIN && octet <= LEAD3_MAX)
               owed_conts = 2'd2;
            else if (octet >= LEAD4_MIN && octet <= LEAD4_MAX)
               owed_conts = 2'd3;
            else begin
               fault_latched = 1'b1;
               fault_kind    = STATUS_BAD_LEAD;
               fault_offset  = next_offset;
            end
         end else if (octet >= CONT_MIN && octet <= CONT_MAX) begin
            owed_conts = owed_conts - 2'd1;
         end else begin
            fault_latched = 1'b1;
            fault_kind    = STATUS_BAD_CONT;
            fault_offset  = next_offset;
         end
      end
      // position saturates rather than wrapping
      if (next_offset != POSITION_MAX)
         next_offset = next_offset + 32'd1;
      if (last) begin
         if (fault_latched)
            verdict = '{status: fault_kind, offset: fault_offset};
         else if (owed_conts != 2'd0)
            verdict = '{status: STATUS_TRUNCATED, offset: next_offset};
         else
            verdict = '{status: STATUS_VALID, offset: 32'd0};
         pending_verdicts.push_back(verdict);
         clear_decoder();
      end
   endtask

   // one word through the input handshake; the sender works in bursts of
   // random length with random gaps in front of them
   task automatic send_word(input logic [7:0] octet, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         // a quarter of the bursts run straight on from the previous one
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid     <= 1'b1;
      req.data_byte <= octet;
      req.last_byte <= last;
      do @(posedge clock); while (!req.ready);
      decode_word(octet, last);
      words_sent++;
      if (last)
         buffers_sent++;
   endtask

   // the whole buffer, the final word marked last; never empty
   task automatic send_buffer(input octet_queue_type octets);
      foreach (octets[i])
         send_word(octets[i], i == octets.size() - 1);
   endtask

   // valid must drop before any wait that does not send
   task automatic idle_sender();
      req.valid     <= 1'b0;
      req.last_byte <= 1'b0;
      burst_left = 0;
   endtask

   // one well-formed character of at least min_len bytes, random content
   function automatic octet_queue_type well_formed_char(input int min_len);
      octet_queue_type chars;
      int              len;
      len = $urandom_range(min_len, 4);
      case (len)
         1: chars.push_back(8'($urandom_range(0, ASCII_MAX)));
         2: chars.push_back(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
         3: chars.push_back(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
         default: chars.push_back(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
      endcase
      repeat (len - 1) chars.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
      return chars;
   endfunction

   task automatic flag_mismatch(input string what, input verdict_type wanted);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display({"mismatch (%s) at %0t: expected status %0d offset %0d,",
                   " got status %0d offset %0d"},
                  what, $realtime, wanted.status, wanted.offset,
                  rsp.status, rsp.error_offset);
   endtask

   // result checker: every accepted result word against the oldest verdict
   always @(posedge clock) begin : check_results
      verdict_type wanted;
      if (!reset && rsp.valid && rsp.ready) begin
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            wanted = '0;
            flag_mismatch("result with none pending", wanted);
         end else begin
            wanted = pending_verdicts.pop_front();
            status_hits[wanted.status]++;
            if (rsp.status !== wanted.status)
               flag_mismatch("status", wanted);
            else if (rsp.error_offset !== wanted.offset)
               flag_mismatch("error offset", wanted);
         end
      end
   end

   // receiver back-pressure: the pattern switches at random
   // between always ready, coin toss, one in four and long stalls
   initial begin : result_stall_pattern
      int mode;
      int left;
      int tick;
      mode = 0;
      left = 0;
      tick = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 80);
         end
         left--;
         tick++;
         case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= 1'($urandom_range(0, 1));
            2: rsp.ready <= (tick % 4 == 0);
            default: rsp.ready <= (tick % 16 >= 12);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached, %0d results outstanding",
                  CYCLE_LIMIT, pending_verdicts.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // single-byte buffers at the ends of the ascii range
   task automatic test_ascii_extremes();
      send_buffer('{8'h00});
      send_buffer('{8'h7F});
   endtask

   // complete two, three and four byte sequences at the edges of each range
   task automatic test_full_sequences();
      send_buffer('{8'hC0, 8'h80, 8'hDF, 8'hBF});
      send_buffer('{8'hE0, 8'hBF, 8'h80});
      send_buffer('{8'hF4, 8'h80, 8'hBF, 8'hBF});
   endtask

   // continuation byte in lead position, leads above f4, bytes after a fault
   task automatic test_bad_leads();
      send_buffer('{8'h80});
      send_buffer('{8'hF5, 8'h41});
      send_buffer('{8'hFF});
   endtask

   // owed continuation replaced by ascii or by another lead
   task automatic test_bad_continuations();
      send_buffer('{8'hC0, 8'h7F});
      send_buffer('{8'hE0, 8'h80, 8'hC0});
   endtask

   // buffer ends while continuation bytes are still owed
   task automatic test_truncation();
      send_buffer('{8'hF0, 8'h80});
      send_buffer('{8'h41, 8'hEF});
   endtask

   // a few buffers, then the sender holds off until every verdict is back
   task automatic test_drain_pause();
      repeat (4) send_buffer(well_formed_char(2));
      idle_sender();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat ($urandom_range(1, 5)) @(posedge clock);
   endtask

   // mostly well-formed text with random content; the rest carries one
   // corrupted byte, a cut-off final character, or is plain noise
   task automatic test_random_buffers();
      octet_queue_type octets;
      octet_queue_type tail;
      int              target;
      int              shape;
      int              at;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         octets.delete();
         shape = $urandom_range(0, 99);
         if (shape < 90)
            repeat ($urandom_range(1, 6)) octets = {octets, well_formed_char(1)};
         if (shape >= 90) begin
            repeat ($urandom_range(1, 12)) octets.push_back(8'($urandom_range(0, 255)));
         end else if (shape >= 80) begin
            tail   = well_formed_char(2);
            tail   = tail[0:$urandom_range(0, tail.size() - 2)];
            octets = {octets, tail};
         end else if (shape >= 62) begin
            at = $urandom_range(0, octets.size() - 1);
            octets[at] = 8'($urandom_range(0, 255));
         end
         send_buffer(octets);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.data_byte <= 8'h00;
      req.last_byte <= 1'b0;
      clear_decoder();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_ascii_extremes();
      test_full_sequences();
      test_bad_leads();
      test_bad_continuations();
      test_truncation();
      test_drain_pause();
      test_random_buffers();

      // let the last verdicts out, then watch for stray results
      idle_sender();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d words in %0d buffers, %0d results checked, %0d mismatches",
               words_sent, buffers_sent, verdicts_seen, mismatches);
      $display("verdicts: %0d valid, %0d bad lead, %0d bad continuation, %0d truncated",
               status_hits[STATUS_VALID], status_hits[STATUS_BAD_LEAD],
               status_hits[STATUS_BAD_CONT], status_hits[STATUS_TRUNCATED]);
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* utf8_stream_validator.f */
rtl/u8v_pkg.sv
rtl/u8v_req_if.sv
rtl/u8v_rsp_if.sv
rtl/u8v_classify.sv
rtl/u8v_scan.sv
rtl/utf8_stream_validator.sv
rtl/u8v_checker.sv
tb/testbench.sv
